>>> design/erot_pkg.sv
package erot_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_WIDTH     = 16;
    localparam int PHASE_WIDTH     = 32;
    localparam int TRIG_WIDTH      = 17;
    localparam int TRIG_FRAC       = 15;
    localparam int TRIG_ONE        = 32768;
    localparam int MID_WIDTH       = COORD_WIDTH + 4;
    localparam int PROD_WIDTH      = TRIG_WIDTH + MID_WIDTH;
    localparam int SUM_WIDTH       = PROD_WIDTH + 1;
    localparam int CORDIC_WIDTH    = 34;
    localparam int CORDIC_STEPS    = 18;
    localparam int STEP_WIDTH      = $clog2(CORDIC_STEPS);
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = ANGLE_WIDTH;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE_X = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE_Y = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE_Z = CFG_INDEX_WIDTH'(2);

    localparam logic [PHASE_WIDTH-1:0] QUAD_HALF = PHASE_WIDTH'(1) << (PHASE_WIDTH - 3);

    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_X0      = CORDIC_WIDTH'(652032874);
    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_ROUND   = CORDIC_WIDTH'(1) << (TRIG_FRAC - 1);
    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_ONE     = CORDIC_WIDTH'(TRIG_ONE);
    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_NEG_ONE = -CORDIC_ONE;

    localparam logic signed [CORDIC_WIDTH-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
        CORDIC_WIDTH'(536870912), CORDIC_WIDTH'(316933406), CORDIC_WIDTH'(167458907),
        CORDIC_WIDTH'(85004756),  CORDIC_WIDTH'(42667331),  CORDIC_WIDTH'(21354465),
        CORDIC_WIDTH'(10680862),  CORDIC_WIDTH'(5340245),   CORDIC_WIDTH'(2670163),
        CORDIC_WIDTH'(1335087),   CORDIC_WIDTH'(667544),    CORDIC_WIDTH'(333772),
        CORDIC_WIDTH'(166886),    CORDIC_WIDTH'(83443),     CORDIC_WIDTH'(41722),
        CORDIC_WIDTH'(20861),     CORDIC_WIDTH'(10430),     CORDIC_WIDTH'(5215)
    };

    localparam logic signed [SUM_WIDTH-1:0] SUM_ROUND = SUM_WIDTH'(1) << (TRIG_FRAC - 1);

    localparam logic signed [MID_WIDTH-1:0] COORD_MAX = MID_WIDTH'((2 ** (COORD_WIDTH - 1)) - 1);
    localparam logic signed [MID_WIDTH-1:0] COORD_MIN = -COORD_MAX - MID_WIDTH'(1);

    typedef struct packed {
        logic signed [TRIG_WIDTH-1:0] sin_val;
        logic signed [TRIG_WIDTH-1:0] cos_val;
    } trig_t;

    localparam trig_t TRIG_RESET = '{sin_val: '0, cos_val: TRIG_WIDTH'(TRIG_ONE)};

    typedef struct packed {
        logic valid;
        logic last;
    } ctl_t;

endpackage

>>> design/erot_if.sv
interface erot_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [erot_pkg::COORD_WIDTH-1:0]  point_x;
    logic signed [erot_pkg::COORD_WIDTH-1:0]  point_y;
    logic signed [erot_pkg::COORD_WIDTH-1:0]  point_z;
    logic                                     last_point;

    modport source (output valid, output point_x, output point_y, output point_z,
                    output last_point, input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  input last_point, output ready);
endinterface

interface erot_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [erot_pkg::COORD_WIDTH-1:0]  rotated_x;
    logic signed [erot_pkg::COORD_WIDTH-1:0]  rotated_y;
    logic signed [erot_pkg::COORD_WIDTH-1:0]  rotated_z;
    logic                                     last_point_out;

    modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
                    output last_point_out, input ready);
    modport sink (input valid, input rotated_x, input rotated_y, input rotated_z,
                  input last_point_out, output ready);
endinterface

>>> design/erot_cordic.sv
module erot_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [erot_pkg::ANGLE_WIDTH-1:0]    angle,
    output logic                                busy,
    output erot_pkg::trig_t                     trig
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_ROUND
    } state_t;

    state_t                                     state_reg;
    logic [erot_pkg::STEP_WIDTH-1:0]            step_reg;
    erot_pkg::trig_t                            trig_reg;
    logic [1:0]                                 quad_reg;
    logic signed [erot_pkg::CORDIC_WIDTH-1:0]   x_reg;
    logic signed [erot_pkg::CORDIC_WIDTH-1:0]   y_reg;
    logic signed [erot_pkg::CORDIC_WIDTH-1:0]   z_reg;
    logic signed [erot_pkg::CORDIC_WIDTH-1:0]   x_next;
    logic signed [erot_pkg::CORDIC_WIDTH-1:0]   y_next;
    logic signed [erot_pkg::CORDIC_WIDTH-1:0]   z_next;

    logic [erot_pkg::PHASE_WIDTH-1:0]           full_angle;
    logic [erot_pkg::PHASE_WIDTH-1:0]           quad_sum;
    logic [1:0]                                 quad;
    logic [erot_pkg::PHASE_WIDTH-1:0]           resid;
    logic signed [erot_pkg::CORDIC_WIDTH-1:0]   resid_ext;
    logic signed [erot_pkg::CORDIC_WIDTH-1:0]   dx;
    logic signed [erot_pkg::CORDIC_WIDTH-1:0]   dy;
    logic signed [erot_pkg::CORDIC_WIDTH-1:0]   atan_val;
    logic signed [erot_pkg::CORDIC_WIDTH-1:0]   x_round;
    logic signed [erot_pkg::CORDIC_WIDTH-1:0]   y_round;
    logic signed [erot_pkg::TRIG_WIDTH-1:0]     cos_val;
    logic signed [erot_pkg::TRIG_WIDTH-1:0]     sin_val;

    function automatic erot_pkg::trig_t quad_map(
        input logic [1:0]                            q,
        input logic signed [erot_pkg::TRIG_WIDTH-1:0] c,
        input logic signed [erot_pkg::TRIG_WIDTH-1:0] s
    );
        erot_pkg::trig_t r;
        case (q)
            2'd0:
            begin
                r.cos_val = c;
                r.sin_val = s;
            end
            2'd1:
            begin
                r.cos_val = -s;
                r.sin_val = c;
            end
            2'd2:
            begin
                r.cos_val = -c;
                r.sin_val = -s;
            end
            default:
            begin
                r.cos_val = s;
                r.sin_val = -c;
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [erot_pkg::TRIG_WIDTH-1:0] clamp_trig(
        input logic signed [erot_pkg::CORDIC_WIDTH-1:0] v
    );
        logic signed [erot_pkg::CORDIC_WIDTH-1:0] c;
        if (v > erot_pkg::CORDIC_ONE)
        begin
            c = erot_pkg::CORDIC_ONE;
        end
        else if (v < erot_pkg::CORDIC_NEG_ONE)
        begin
            c = erot_pkg::CORDIC_NEG_ONE;
        end
        else
        begin
            c = v;
        end
        return c[erot_pkg::TRIG_WIDTH-1:0];
    endfunction

    // The angle is split into the nearest quarter turn and a residual of at most an eighth.
    always_comb
    begin
        full_angle = {angle, {(erot_pkg::PHASE_WIDTH - erot_pkg::ANGLE_WIDTH){1'b0}}};
        quad_sum   = full_angle + erot_pkg::QUAD_HALF;
        quad       = quad_sum[erot_pkg::PHASE_WIDTH-1:erot_pkg::PHASE_WIDTH-2];
        resid      = full_angle - {quad, {(erot_pkg::PHASE_WIDTH - 2){1'b0}}};
        resid_ext  = erot_pkg::CORDIC_WIDTH'(signed'(resid));
    end

    always_comb
    begin
        dx       = y_reg >>> step_reg;
        dy       = x_reg >>> step_reg;
        atan_val = erot_pkg::ATAN_TABLE[step_reg];
        if (!z_reg[erot_pkg::CORDIC_WIDTH-1])
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - atan_val;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + atan_val;
        end
        x_round = (x_reg + erot_pkg::CORDIC_ROUND) >>> erot_pkg::TRIG_FRAC;
        y_round = (y_reg + erot_pkg::CORDIC_ROUND) >>> erot_pkg::TRIG_FRAC;
        cos_val = clamp_trig(x_round);
        sin_val = clamp_trig(y_round);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            trig_reg  <= erot_pkg::TRIG_RESET;
        end
        else if (start)
        begin
            step_reg <= '0;
            if (resid == '0)
            begin
                trig_reg  <= quad_map(quad, erot_pkg::TRIG_WIDTH'(erot_pkg::TRIG_ONE), '0);
                state_reg <= ST_IDLE;
            end
            else
            begin
                state_reg <= ST_ITER;
            end
        end
        else
        begin
            case (state_reg)
                ST_ITER:
                begin
                    if (step_reg == erot_pkg::STEP_WIDTH'(erot_pkg::CORDIC_STEPS - 1))
                    begin
                        state_reg <= ST_ROUND;
                    end
                    else
                    begin
                        step_reg <= step_reg + erot_pkg::STEP_WIDTH'(1);
                    end
                end
                ST_ROUND:
                begin
                    trig_reg  <= quad_map(quad_reg, cos_val, sin_val);
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quad_reg <= quad;
            x_reg    <= erot_pkg::CORDIC_X0;
            y_reg    <= '0;
            z_reg    <= resid_ext;
        end
        else if (state_reg == ST_ITER)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign trig = trig_reg;

endmodule

>>> design/erot_axis.sv
module erot_axis (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  erot_pkg::ctl_t                      ctl_in,
    input  logic signed [erot_pkg::MID_WIDTH-1:0] u,
    input  logic signed [erot_pkg::MID_WIDTH-1:0] v,
    input  logic signed [erot_pkg::MID_WIDTH-1:0] w,
    input  erot_pkg::trig_t                     trig,
    output erot_pkg::ctl_t                      ctl_out,
    output logic signed [erot_pkg::MID_WIDTH-1:0] p,
    output logic signed [erot_pkg::MID_WIDTH-1:0] q,
    output logic signed [erot_pkg::MID_WIDTH-1:0] w_out
);

    // The first stage forms the four products, the second stage sums and rounds them:
    // p = cos * u - sin * v and q = sin * u + cos * v.

    logic signed [erot_pkg::TRIG_WIDTH-1:0]  cos_s;
    logic signed [erot_pkg::TRIG_WIDTH-1:0]  sin_s;

    erot_pkg::ctl_t                          ctl_a_reg;
    logic signed [erot_pkg::PROD_WIDTH-1:0]  cu_reg;
    logic signed [erot_pkg::PROD_WIDTH-1:0]  sv_reg;
    logic signed [erot_pkg::PROD_WIDTH-1:0]  su_reg;
    logic signed [erot_pkg::PROD_WIDTH-1:0]  cv_reg;
    logic signed [erot_pkg::MID_WIDTH-1:0]   w_a_reg;
    logic signed [erot_pkg::PROD_WIDTH-1:0]  cu_next;
    logic signed [erot_pkg::PROD_WIDTH-1:0]  sv_next;
    logic signed [erot_pkg::PROD_WIDTH-1:0]  su_next;
    logic signed [erot_pkg::PROD_WIDTH-1:0]  cv_next;

    erot_pkg::ctl_t                          ctl_b_reg;
    logic signed [erot_pkg::MID_WIDTH-1:0]   p_reg;
    logic signed [erot_pkg::MID_WIDTH-1:0]   q_reg;
    logic signed [erot_pkg::MID_WIDTH-1:0]   w_b_reg;
    logic signed [erot_pkg::SUM_WIDTH-1:0]   p_sum;
    logic signed [erot_pkg::SUM_WIDTH-1:0]   q_sum;
    logic signed [erot_pkg::SUM_WIDTH-1:0]   p_shift;
    logic signed [erot_pkg::SUM_WIDTH-1:0]   q_shift;
    logic signed [erot_pkg::MID_WIDTH-1:0]   p_next;
    logic signed [erot_pkg::MID_WIDTH-1:0]   q_next;

    assign cos_s = trig.cos_val;
    assign sin_s = trig.sin_val;

    always_comb
    begin
        cu_next = erot_pkg::PROD_WIDTH'(cos_s) * erot_pkg::PROD_WIDTH'(u);
        sv_next = erot_pkg::PROD_WIDTH'(sin_s) * erot_pkg::PROD_WIDTH'(v);
        su_next = erot_pkg::PROD_WIDTH'(sin_s) * erot_pkg::PROD_WIDTH'(u);
        cv_next = erot_pkg::PROD_WIDTH'(cos_s) * erot_pkg::PROD_WIDTH'(v);
    end

    always_comb
    begin
        p_sum   = erot_pkg::SUM_WIDTH'(cu_reg) - erot_pkg::SUM_WIDTH'(sv_reg)
                  + erot_pkg::SUM_ROUND;
        q_sum   = erot_pkg::SUM_WIDTH'(su_reg) + erot_pkg::SUM_WIDTH'(cv_reg)
                  + erot_pkg::SUM_ROUND;
        p_shift = p_sum >>> erot_pkg::TRIG_FRAC;
        q_shift = q_sum >>> erot_pkg::TRIG_FRAC;
        p_next  = p_shift[erot_pkg::MID_WIDTH-1:0];
        q_next  = q_shift[erot_pkg::MID_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cu_reg  <= cu_next;
            sv_reg  <= sv_next;
            su_reg  <= su_next;
            cv_reg  <= cv_next;
            w_a_reg <= w;
            p_reg   <= p_next;
            q_reg   <= q_next;
            w_b_reg <= w_a_reg;
        end
    end

    assign ctl_out = ctl_b_reg;
    assign p       = p_reg;
    assign q       = q_reg;
    assign w_out   = w_b_reg;

endmodule

>>> design/euler_rotate_3d_points_top.sv
// Rotates a stream of 3D points about X, then Y, then Z.
// Points arrive on the points channel and rotated points leave on the results channel,
// both valid/ready; a transaction happens when valid and ready are high at a clock edge.
// Coordinates are signed Q3.12; results saturate to the 16-bit range, and the
// last-point flag travels with its point unchanged.
// The three angles are written through cfg_we, cfg_index and cfg_data, in units of
// 1/65536 of a turn; writes to an index above 2 are ignored. Each write starts a CORDIC
// unit of its axis that produces the sine and cosine in 18 iterations plus a rounding
// step, so points ready stays low until that unit is done, or not at all when
// the angle is a whole number of quarter turns.
// The datapath is a six-stage pipeline (a multiply stage and a sum stage per axis)
// followed by the output register; one point is accepted every cycle while no CORDIC
// unit is busy and the receiver does not stall.
// When the receiver stalls, the whole pipeline holds and points ready falls with it;
// nothing is dropped or repeated.
// Reset clears the pipeline and sets all angles to zero (the identity rotation).
module euler_rotate_3d_points_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [erot_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [erot_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    erot_in_if.sink                                 points,
    erot_out_if.source                              results
);

    logic                                   en;
    logic                                   busy_x;
    logic                                   busy_y;
    logic                                   busy_z;
    logic                                   start_x;
    logic                                   start_y;
    logic                                   start_z;
    erot_pkg::trig_t                        trig_x;
    erot_pkg::trig_t                        trig_y;
    erot_pkg::trig_t                        trig_z;

    erot_pkg::ctl_t                         ctl_in;
    erot_pkg::ctl_t                         ctl_x;
    erot_pkg::ctl_t                         ctl_y;
    erot_pkg::ctl_t                         ctl_z;
    logic signed [erot_pkg::MID_WIDTH-1:0]  px;
    logic signed [erot_pkg::MID_WIDTH-1:0]  py;
    logic signed [erot_pkg::MID_WIDTH-1:0]  pz;
    logic signed [erot_pkg::MID_WIDTH-1:0]  xy;
    logic signed [erot_pkg::MID_WIDTH-1:0]  xz;
    logic signed [erot_pkg::MID_WIDTH-1:0]  x_pass;
    logic signed [erot_pkg::MID_WIDTH-1:0]  yz;
    logic signed [erot_pkg::MID_WIDTH-1:0]  yx;
    logic signed [erot_pkg::MID_WIDTH-1:0]  y_pass;
    logic signed [erot_pkg::MID_WIDTH-1:0]  zx;
    logic signed [erot_pkg::MID_WIDTH-1:0]  zy;
    logic signed [erot_pkg::MID_WIDTH-1:0]  z_pass;

    logic                                   out_valid_reg;
    logic                                   out_last_reg;
    logic signed [erot_pkg::COORD_WIDTH-1:0] out_x_reg;
    logic signed [erot_pkg::COORD_WIDTH-1:0] out_y_reg;
    logic signed [erot_pkg::COORD_WIDTH-1:0] out_z_reg;
    logic signed [erot_pkg::COORD_WIDTH-1:0] out_x_next;
    logic signed [erot_pkg::COORD_WIDTH-1:0] out_y_next;
    logic signed [erot_pkg::COORD_WIDTH-1:0] out_z_next;

    function automatic logic signed [erot_pkg::COORD_WIDTH-1:0] sat_coord(
        input logic signed [erot_pkg::MID_WIDTH-1:0] v
    );
        logic signed [erot_pkg::MID_WIDTH-1:0] c;
        if (v > erot_pkg::COORD_MAX)
        begin
            c = erot_pkg::COORD_MAX;
        end
        else if (v < erot_pkg::COORD_MIN)
        begin
            c = erot_pkg::COORD_MIN;
        end
        else
        begin
            c = v;
        end
        return c[erot_pkg::COORD_WIDTH-1:0];
    endfunction

    assign start_x = cfg_we && (cfg_index == erot_pkg::REG_ANGLE_X);
    assign start_y = cfg_we && (cfg_index == erot_pkg::REG_ANGLE_Y);
    assign start_z = cfg_we && (cfg_index == erot_pkg::REG_ANGLE_Z);

    erot_cordic u_cordic_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_x),
        .angle (cfg_data[erot_pkg::ANGLE_WIDTH-1:0]),
        .busy  (busy_x),
        .trig  (trig_x)
    );

    erot_cordic u_cordic_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_y),
        .angle (cfg_data[erot_pkg::ANGLE_WIDTH-1:0]),
        .busy  (busy_y),
        .trig  (trig_y)
    );

    erot_cordic u_cordic_z (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_z),
        .angle (cfg_data[erot_pkg::ANGLE_WIDTH-1:0]),
        .busy  (busy_z),
        .trig  (trig_z)
    );

    assign en           = !out_valid_reg || results.ready;
    assign points.ready = en && !busy_x && !busy_y && !busy_z;

    assign ctl_in.valid = points.valid && points.ready;
    assign ctl_in.last  = points.last_point;
    assign px = erot_pkg::MID_WIDTH'(points.point_x);
    assign py = erot_pkg::MID_WIDTH'(points.point_y);
    assign pz = erot_pkg::MID_WIDTH'(points.point_z);

    erot_axis u_axis_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_in),
        .u       (py),
        .v       (pz),
        .w       (px),
        .trig    (trig_x),
        .ctl_out (ctl_x),
        .p       (xy),
        .q       (xz),
        .w_out   (x_pass)
    );

    erot_axis u_axis_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_x),
        .u       (xz),
        .v       (x_pass),
        .w       (xy),
        .trig    (trig_y),
        .ctl_out (ctl_y),
        .p       (yz),
        .q       (yx),
        .w_out   (y_pass)
    );

    erot_axis u_axis_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_y),
        .u       (yx),
        .v       (y_pass),
        .w       (yz),
        .trig    (trig_z),
        .ctl_out (ctl_z),
        .p       (zx),
        .q       (zy),
        .w_out   (z_pass)
    );

    always_comb
    begin
        out_x_next = sat_coord(zx);
        out_y_next = sat_coord(zy);
        out_z_next = sat_coord(z_pass);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl_z.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_last_reg <= ctl_z.last;
            out_x_reg    <= out_x_next;
            out_y_reg    <= out_y_next;
            out_z_reg    <= out_z_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.rotated_x      = out_x_reg;
    assign results.rotated_y      = out_y_reg;
    assign results.rotated_z      = out_z_reg;
    assign results.last_point_out = out_last_reg;

endmodule
